// ===== sv/bwv_pkg.sv =====
// Package for the battery warning voter: slot counts, codes and payload types.
// Used by the channel interfaces and the top level.
`timescale 1ns / 1ps

package bwv_pkg;

  localparam int unsigned SINGLE_SLOTS = 4;
  localparam int unsigned PACK_SLOTS   = 4;
  localparam int unsigned RAW_SLOTS    = SINGLE_SLOTS + PACK_SLOTS;
  localparam int unsigned SLOT_COUNT   = (RAW_SLOTS > 8) ? 8 : RAW_SLOTS;
  localparam int unsigned SLOT_DEPTH   = 8;
  localparam int unsigned SLOT_W       = 3;
  localparam int unsigned CNT_W        = 4;

  localparam logic [1:0] MODE_STATUS  = 2'd0;
  localparam logic [1:0] MODE_REPORT  = 2'd1;
  localparam logic [1:0] MODE_PUBLISH = 2'd2;

  localparam logic [1:0] WARN_NONE = 2'd0;
  localparam logic [1:0] WARN_CRIT = 2'd1;
  localparam logic [1:0] WARN_EMER = 2'd2;

  localparam logic [1:0] REG_DROP_DELAY = 2'd0;
  localparam logic [1:0] REG_ADV_EN     = 2'd1;

  localparam logic [31:0] DROP_DELAY_RESET = 32'd1000000;

  typedef struct packed {
    logic [1:0]  mode;
    logic [2:0]  slot;
    logic [31:0] now_us;
    logic [15:0] level;
    logic [15:0] critical_level;
    logic [15:0] emergency_level;
    logic [7:0]  battery_id;
    logic [15:0] voltage_mv;
    logic [15:0] run_time;
    logic        connected;
    logic        armed_in;
    logic        redundant_in;
  } bwv_in_t;

  typedef struct packed {
    logic [1:0]  warning;
    logic [7:0]  cause_id;
    logic [15:0] source_voltage_mv;
    logic [15:0] source_run_time;
  } bwv_out_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [31:0] data;
  } bwv_cfg_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] volt;
    logic [15:0] rt;
  } bwv_cand_t;

  typedef struct packed {
    logic [1:0]  warn;
    logic [31:0] crit_ts;
    logic [31:0] emer_ts;
  } bwv_entry_t;

endpackage

// ===== sv/bwv_if.sv =====
// Handshake channels of the battery warning voter: input, result, configuration.
// Depends on bwv_pkg for the payload types.
`timescale 1ns / 1ps

interface bwv_in_if import bwv_pkg::*; ();
  logic    valid;
  logic    ready;
  bwv_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bwv_out_if import bwv_pkg::*; ();
  logic     valid;
  logic     ready;
  bwv_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bwv_cfg_if import bwv_pkg::*; ();
  logic     valid;
  logic     ready;
  bwv_cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/battery_warning_voter.sv =====
// Battery warning voter: a report does one read and one write-back of the slot memory;
// a publish does one read per slot then the vote, which waits while an earlier result is
// still pending, and registers the result; a status item only updates the flags.
// One item is worked at a time; the result register frees the input while it waits.
// Reset (async, active low) clears flags, candidates, the published status and the
// per-slot valid bits, so every slot reads as no warning and zero stamps.
`timescale 1ns / 1ps

module battery_warning_voter import bwv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  bwv_in_if.sink     in_i,
  bwv_out_if.source  out_o,
  bwv_cfg_if.sink    cfg_i
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_UPD  = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_VOTE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [31:0] drop_delay_q;
  logic        adv_en_q;
  logic        armed_q, redundant_q;
  bwv_cand_t   crit_cand_q, emer_cand_q;
  logic [1:0]  pub_warn_q;
  bwv_cand_t   pub_src_q;
  logic        out_valid_q;

  logic [SLOT_DEPTH-1:0] vld_q;
  bwv_entry_t mem_q [SLOT_DEPTH];
  bwv_entry_t rd_q;
  logic       rd_vld_q;

  bwv_in_t    item_q;
  logic [CNT_W-1:0] cnt_q;
  logic [CNT_W-1:0] nemer_q, ncrit_q;

  logic        in_acc, cfg_acc, out_acc;
  logic        rd_en;
  logic [SLOT_W-1:0] rd_addr;
  logic        mem_we;
  bwv_entry_t  cur, wr_data;
  logic        slot_ok;
  logic [31:0] age_c, age_e;
  logic        stale_c, stale_e;
  logic [1:0]  new_warn;
  logic        raise;
  logic [CNT_W-1:0] need;
  logic [1:0]  vote_lvl;
  logic        vote_go;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_acc  = in_i.valid && in_i.ready;
  assign cfg_acc = cfg_i.valid && cfg_i.ready;
  assign out_acc = out_o.valid && out_o.ready;

  assign out_o.valid                  = out_valid_q;
  assign out_o.data.warning           = pub_warn_q;
  assign out_o.data.cause_id          = pub_src_q.id;
  assign out_o.data.source_voltage_mv = pub_src_q.volt;
  assign out_o.data.source_run_time   = pub_src_q.rt;

  assign slot_ok = ({1'b0, in_i.data.slot} < CNT_W'(SLOT_COUNT)) && in_i.data.connected
                   && armed_q;

  // read-modify-write of one slot entry
  assign cur = rd_vld_q ? rd_q : '0;
  always_comb begin
    wr_data = cur;
    if (item_q.level > item_q.critical_level) begin
      wr_data.crit_ts = item_q.now_us;
    end
    if (item_q.level > item_q.emergency_level) begin
      wr_data.emer_ts = item_q.now_us;
    end
    age_c   = item_q.now_us - wr_data.crit_ts;
    age_e   = item_q.now_us - wr_data.emer_ts;
    stale_c = age_c > drop_delay_q;
    stale_e = age_e > drop_delay_q;
    if (stale_e || cur.warn == WARN_EMER) begin
      new_warn = WARN_EMER;
    end else if (stale_c || cur.warn == WARN_CRIT) begin
      new_warn = WARN_CRIT;
    end else begin
      new_warn = WARN_NONE;
    end
    raise = new_warn > cur.warn;
    if (raise) begin
      wr_data.warn = new_warn;
    end
  end

  // vote on the counted levels
  always_comb begin
    need = (adv_en_q && redundant_q) ? CNT_W'(2) : CNT_W'(1);
    if (nemer_q >= need) begin
      vote_lvl = WARN_EMER;
    end else if ((ncrit_q + nemer_q) >= need) begin
      vote_lvl = WARN_CRIT;
    end else begin
      vote_lvl = WARN_NONE;
    end
    vote_go = !out_valid_q || out_o.ready;
  end

  always_comb begin
    state_d = state_q;
    rd_en   = 1'b0;
    rd_addr = in_i.data.slot;
    mem_we  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && in_i.data.mode == MODE_REPORT && slot_ok) begin
          rd_en   = 1'b1;
          state_d = ST_UPD;
        end else if (in_acc && in_i.data.mode == MODE_PUBLISH) begin
          rd_en   = 1'b1;
          rd_addr = '0;
          state_d = ST_SCAN;
        end
      end
      ST_UPD: begin
        mem_we  = 1'b1;
        state_d = ST_IDLE;
      end
      ST_SCAN: begin
        if (cnt_q == CNT_W'(SLOT_COUNT)) begin
          state_d = ST_VOTE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = cnt_q[SLOT_W-1:0];
        end
      end
      ST_VOTE: begin
        if (vote_go) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[item_q.slot] <= wr_data;
    end
    if (rd_en) begin
      rd_q     <= mem_q[rd_addr];
      rd_vld_q <= vld_q[rd_addr];
    end
    if (in_acc) begin
      item_q <= in_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      drop_delay_q <= DROP_DELAY_RESET;
      adv_en_q     <= 1'b0;
      armed_q      <= 1'b0;
      redundant_q  <= 1'b0;
      crit_cand_q  <= '0;
      emer_cand_q  <= '0;
      pub_warn_q   <= WARN_NONE;
      pub_src_q    <= '0;
      out_valid_q  <= 1'b0;
      vld_q        <= '0;
      cnt_q        <= '0;
      nemer_q      <= '0;
      ncrit_q      <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_acc && cfg_i.data.index == REG_DROP_DELAY) begin
        drop_delay_q <= cfg_i.data.data;
      end
      if (cfg_acc && cfg_i.data.index == REG_ADV_EN) begin
        adv_en_q <= cfg_i.data.data[0];
      end
      if (in_acc && in_i.data.mode == MODE_STATUS) begin
        armed_q     <= in_i.data.armed_in;
        redundant_q <= in_i.data.redundant_in;
      end
      if (in_acc) begin
        cnt_q   <= CNT_W'(1);
        nemer_q <= '0;
        ncrit_q <= '0;
      end
      if (mem_we) begin
        vld_q[item_q.slot] <= 1'b1;
        if (raise && new_warn == WARN_EMER) begin
          emer_cand_q <= '{id: item_q.battery_id, volt: item_q.voltage_mv,
                           rt: item_q.run_time};
        end
        if (raise && new_warn == WARN_CRIT) begin
          crit_cand_q <= '{id: item_q.battery_id, volt: item_q.voltage_mv,
                           rt: item_q.run_time};
        end
      end
      // accumulate the slot read in the previous cycle
      if (state_q == ST_SCAN && cnt_q != CNT_W'(SLOT_COUNT)) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (state_q == ST_SCAN) begin
        if (cur.warn == WARN_EMER) begin
          nemer_q <= nemer_q + CNT_W'(1);
        end else if (cur.warn == WARN_CRIT) begin
          ncrit_q <= ncrit_q + CNT_W'(1);
        end
      end
      if (out_acc) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == ST_VOTE && vote_go) begin
        out_valid_q <= 1'b1;
        if (vote_lvl > pub_warn_q) begin
          pub_warn_q <= vote_lvl;
          pub_src_q  <= (vote_lvl == WARN_EMER) ? emer_cand_q : crit_cand_q;
        end
      end
    end
  end

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register not one-hot");

  a_pub_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> pub_warn_q >= $past(pub_warn_q))
    else $error("published warning fell");

  a_pub_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pub_warn_q == WARN_NONE |-> pub_src_q == '0)
    else $error("source set while no warning published");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> cnt_q <= CNT_W'(SLOT_COUNT))
    else $error("slot scan ran past the slot count");

  a_vote_holds_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_VOTE && out_valid_q && !out_o.ready |=> state_q == ST_VOTE)
    else $error("publish left vote while result still pending");

endmodule

// ===== tb/bwv_checker.sv =====
// Checker for the battery warning voter: watches the input, result and configuration
// channels, tracks slot warnings and the published status, and compares every result.
// Depends on bwv_pkg for codes, slot counts and payload types.
`timescale 1ns / 1ps

module bwv_checker import bwv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  bwv_in_t     in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  bwv_out_t    out_data_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  bwv_cfg_t    cfg_data_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  logic [31:0] drop_delay;
  logic        adv_en;
  logic [1:0]  slot_warn [SLOT_DEPTH];
  logic [31:0] crit_seen [SLOT_DEPTH];
  logic [31:0] emer_seen [SLOT_DEPTH];
  logic        armed;
  logic        redundant;
  bwv_cand_t   crit_cand;
  bwv_cand_t   emer_cand;
  bwv_cand_t   pub_src;
  logic [1:0]  pub_warn;
  bwv_out_t    status_due [$];

  function automatic logic is_stale(input logic [31:0] now, input logic [31:0] stamp);
    logic [31:0] age;
    age = now - stamp;
    return age > drop_delay;
  endfunction

  task automatic clear_state();
    int i;
    drop_delay = DROP_DELAY_RESET;
    adv_en     = 1'b0;
    for (i = 0; i < SLOT_DEPTH; i++) begin
      slot_warn[i] = WARN_NONE;
      crit_seen[i] = '0;
      emer_seen[i] = '0;
    end
    armed     = 1'b0;
    redundant = 1'b0;
    crit_cand = '0;
    emer_cand = '0;
    pub_src   = '0;
    pub_warn  = WARN_NONE;
    status_due.delete();
  endtask

  task automatic track_item(input bwv_in_t it);
    int unsigned i;
    int unsigned n_emer;
    int unsigned n_crit;
    int unsigned need;
    logic [2:0]  s;
    logic [1:0]  nw;
    logic [1:0]  lvl;
    bwv_cand_t   cand;
    bwv_out_t    st;
    n_emer = 0;
    n_crit = 0;
    case (it.mode)
      MODE_STATUS: begin
        armed     = it.armed_in;
        redundant = it.redundant_in;
      end
      MODE_REPORT: begin
        if (it.slot < SLOT_COUNT && it.connected && armed) begin
          s = it.slot;
          if (it.level > it.critical_level) crit_seen[s] = it.now_us;
          if (it.level > it.emergency_level) emer_seen[s] = it.now_us;
          if (is_stale(it.now_us, emer_seen[s]) || slot_warn[s] == WARN_EMER) begin
            nw = WARN_EMER;
          end else if (is_stale(it.now_us, crit_seen[s]) || slot_warn[s] == WARN_CRIT) begin
            nw = WARN_CRIT;
          end else begin
            nw = WARN_NONE;
          end
          if (nw > slot_warn[s]) begin
            slot_warn[s] = nw;
            cand.id   = it.battery_id;
            cand.volt = it.voltage_mv;
            cand.rt   = it.run_time;
            if (nw == WARN_EMER) emer_cand = cand;
            else crit_cand = cand;
          end
        end
      end
      MODE_PUBLISH: begin
        for (i = 0; i < SLOT_COUNT; i++) begin
          if (slot_warn[i] == WARN_EMER) n_emer++;
          else if (slot_warn[i] == WARN_CRIT) n_crit++;
        end
        need = (adv_en && redundant) ? 2 : 1;
        lvl = WARN_NONE;
        if (n_emer >= need) lvl = WARN_EMER;
        else if (n_crit + n_emer >= need) lvl = WARN_CRIT;
        if (lvl > pub_warn) begin
          pub_warn = lvl;
          pub_src  = (lvl == WARN_EMER) ? emer_cand : crit_cand;
        end
        st.warning           = pub_warn;
        st.cause_id          = pub_src.id;
        st.source_voltage_mv = pub_src.volt;
        st.source_run_time   = pub_src.rt;
        status_due.push_back(st);
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $display("%0t bwv_checker: %s expected %0h actual %0h", $time, name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    bwv_out_t want;
    if (!rst_ni) begin
      clear_state();
      fail_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_data_i.index == REG_DROP_DELAY) drop_delay = cfg_data_i.data;
        else if (cfg_data_i.index == REG_ADV_EN) adv_en = cfg_data_i.data[0];
      end
      // check the result before tracking a new item in the same cycle
      if (out_valid_i && out_ready_i) begin
        if (status_due.size() == 0) begin
          $display("%0t bwv_checker: unexpected status expected none actual %0h", $time,
                   out_data_i);
          fail_count_o++;
        end else begin
          want = status_due.pop_front();
          check_field("warning", want.warning, out_data_i.warning);
          check_field("cause_id", want.cause_id, out_data_i.cause_id);
          check_field("source_voltage_mv", want.source_voltage_mv,
                      out_data_i.source_voltage_mv);
          check_field("source_run_time", want.source_run_time, out_data_i.source_run_time);
        end
      end
      if (in_valid_i && in_ready_i) track_item(in_data_i);
    end
    pending_o = status_due.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// Top of the battery warning voter testbench: clock, reset, stimulus phases over
// several register settings, random idling on both sides and the verdict.
// Depends on bwv_pkg, the bwv channel interfaces, battery_warning_voter and bwv_checker.
`timescale 1ns / 1ps

module tb_top;
  import bwv_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned LONG_HOLD     = 400;
  localparam logic [1:0]  MODE_UNUSED   = 2'd3;
  localparam int unsigned LVL_ABOVE     = 0;
  localparam int unsigned LVL_BETWEEN   = 1;
  localparam int unsigned LVL_BELOW     = 2;

  logic        clk;
  logic        rst_n;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycles = 0;
  bit          no_idle;
  bit          hold_go;
  bit          hold_done;
  logic [31:0] clock_us;

  bwv_in_if  in_ch ();
  bwv_out_if out_ch ();
  bwv_cfg_if cfg_ch ();

  battery_warning_voter u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  bwv_checker u_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_ch.valid),
    .in_ready_i   (in_ch.ready),
    .in_data_i    (in_ch.data),
    .out_valid_i  (out_ch.valid),
    .out_ready_i  (out_ch.ready),
    .out_data_i   (out_ch.data),
    .cfg_valid_i  (cfg_ch.valid),
    .cfg_ready_i  (cfg_ch.ready),
    .cfg_data_i   (cfg_ch.data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic bwv_in_t noise_item();
    bwv_in_t it;
    it = {$urandom(), $urandom(), $urandom(), $urandom()};
    return it;
  endfunction

  function automatic bwv_in_t status_item(input logic armed_v, input logic red_v);
    bwv_in_t it;
    it = noise_item();
    it.mode         = MODE_STATUS;
    it.armed_in     = armed_v;
    it.redundant_in = red_v;
    return it;
  endfunction

  function automatic bwv_in_t publish_item();
    bwv_in_t it;
    it = noise_item();
    it.mode = MODE_PUBLISH;
    return it;
  endfunction

  function automatic bwv_in_t fixed_report(input logic [2:0] slot, input logic [31:0] now,
                                           input logic [15:0] lvl, input logic [15:0] crit,
                                           input logic [15:0] emer, input logic conn);
    bwv_in_t it;
    it = noise_item();
    it.mode            = MODE_REPORT;
    it.slot            = slot;
    it.now_us          = now;
    it.level           = lvl;
    it.critical_level  = crit;
    it.emergency_level = emer;
    it.connected       = conn;
    return it;
  endfunction

  function automatic bwv_in_t report_item(input logic [2:0] slot, input logic [31:0] now,
                                          input int unsigned kind);
    bwv_in_t it;
    it = noise_item();
    it.mode      = MODE_REPORT;
    it.slot      = slot;
    it.now_us    = now;
    it.connected = ($urandom_range(0, 19) != 0);
    if (kind == LVL_ABOVE) begin
      it.level           = 16'($urandom_range(1, 65535));
      it.critical_level  = 16'($urandom_range(0, it.level - 1));
      it.emergency_level = 16'($urandom_range(0, it.level - 1));
    end else if (kind == LVL_BETWEEN) begin
      it.level           = 16'($urandom_range(1, 65535));
      it.critical_level  = 16'($urandom_range(it.level, 65535));
      it.emergency_level = 16'($urandom_range(0, it.level - 1));
    end else begin
      it.level           = 16'($urandom_range(0, 65535));
      it.critical_level  = 16'($urandom_range(it.level, 65535));
      it.emergency_level = 16'($urandom_range(it.level, 65535));
    end
    return it;
  endfunction

  // Call at a falling edge; returns at a falling edge with valid still high.
  task automatic send_item(input bwv_in_t it);
    int unsigned g;
    g = idle_len();
    if (g != 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    bwv_cfg_t c;
    c.index = idx;
    c.data  = val;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= c;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_noise(input int unsigned n);
    int unsigned k;
    for (k = 0; k < n; k++) begin
      no_idle = ((k / 50) % 4 == 3);
      send_item(noise_item());
    end
    no_idle = 1'b0;
  endtask

  // Mostly armed reports on a running clock, mixed with status, publish and noise.
  task automatic run_sequence(input int unsigned n, input int unsigned step_max,
                              input bit calm, input bit jumps);
    int unsigned k;
    int unsigned r;
    int unsigned kind;
    bwv_in_t     it;
    for (k = 0; k < n; k++) begin
      no_idle = ((k / 50) % 4 == 3);
      r = $urandom_range(0, 99);
      if (r < 6) begin
        it = status_item($urandom_range(0, 9) != 0, 1'($urandom_range(0, 1)));
      end else if (r < 24) begin
        it = publish_item();
      end else if (r < 88) begin
        if (jumps && $urandom_range(0, 49) == 0) clock_us += $urandom();
        else clock_us += $urandom_range(0, step_max);
        r = $urandom_range(0, 99);
        kind = (r < 75) ? LVL_ABOVE : (r < 87) ? LVL_BETWEEN : LVL_BELOW;
        it = report_item(3'($urandom_range(0, 7)), clock_us, kind);
      end else begin
        it = noise_item();
        if (calm && it.mode == MODE_REPORT) it.connected = 1'b0;
      end
      send_item(it);
    end
    no_idle = 1'b0;
  endtask

  initial begin : rx_side
    int unsigned g;
    out_ch.ready = 1'b0;
    hold_done    = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_go && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_done = 1'b1;
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(negedge clk);
      g = idle_len();
      if (g != 0) begin
        out_ch.ready <= 1'b0;
        repeat (g) @(negedge clk);
      end
    end
  end

  initial begin : stim
    bwv_in_t     it;
    int unsigned s;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    no_idle      = 1'b0;
    hold_go      = 1'b0;
    clock_us     = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: ignored items, stamp refresh on every slot, equal thresholds
    send_item(publish_item());
    it = noise_item();
    it.mode = MODE_UNUSED;
    send_item(it);
    send_item(fixed_report(3'd7, 32'hFFFF_FFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b1));
    send_item(status_item(1'b1, 1'b1));
    send_item(fixed_report(3'd0, 32'hFFFF_FFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b0));
    send_item(publish_item());
    for (s = 0; s < 8; s++) begin
      it = fixed_report(s[2:0], 100 * s, 16'hFFFF, 16'h0000, 16'h0000, 1'b1);
      it.battery_id = s[0] ? 8'hFF : 8'h00;
      it.voltage_mv = s[0] ? 16'hFFFF : 16'h0000;
      it.run_time   = s[0] ? 16'hFFFF : 16'h0000;
      send_item(it);
    end
    send_item(fixed_report(3'd3, 32'd2000, 16'h0000, 16'h0000, 16'h0000, 1'b1));
    send_item(fixed_report(3'd5, 32'd2100, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
    send_item(status_item(1'b1, 1'b0));
    send_item(publish_item());
    send_item(status_item(1'b0, 1'b0));
    send_item(fixed_report(3'd2, 32'hFFFF_FFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b1));
    send_item(status_item(1'b1, 1'b1));
    send_item(publish_item());

    clock_us = 32'd3000;
    run_sequence(300, 300, 1'b1, 1'b0);

    // never stale: free noise while the result side holds off
    in_ch.valid <= 1'b0;
    write_reg(REG_DROP_DELAY, 32'hFFFF_FFFF);
    write_reg(REG_ADV_EN, 32'd1);
    hold_go = 1'b1;
    run_noise(400);

    // refresh every slot, then latch gradually with two-battery voting
    in_ch.valid <= 1'b0;
    write_reg(REG_DROP_DELAY, 32'd3000);
    clock_us += 32'd100000;
    send_item(status_item(1'b1, 1'b1));
    for (s = 0; s < 8; s++) begin
      it = report_item(s[2:0], clock_us, LVL_ABOVE);
      it.connected = 1'b1;
      send_item(it);
    end
    run_sequence(430, 400, 1'b1, 1'b0);

    in_ch.valid <= 1'b0;
    write_reg(REG_DROP_DELAY, 32'd0);
    write_reg(REG_ADV_EN, 32'd0);
    run_sequence(280, 200, 1'b0, 1'b1);

    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
